// File: src/hrbm_pkg.sv
// Hash range bucket mask: shared types, constants and the divider step.
// Used by every module of hash_range_bucket_mask_unit; depends on nothing.
package hrbm_pkg;

  localparam int KEY_BITS        = 16;
  localparam int MASK_BITS       = 64;
  localparam int QUOT_BITS       = $clog2(MASK_BITS);
  localparam int QUOT_IDX_BITS   = $clog2(QUOT_BITS);
  localparam int WIDTH_BITS      = KEY_BITS - QUOT_BITS + 1;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QUOT_BITS / STEPS_PER_STAGE;
  localparam int LATENCY         = DIV_STAGES + 3;
  localparam int CFG_INDEX_BITS  = 1;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [QUOT_BITS-1:0]  quot_t;
  typedef logic [MASK_BITS-1:0]  mask_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PARTITION_LOW  = 1'b0,
    REG_PARTITION_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ACT_POINT  = 1'b0,
    ACT_REGION = 1'b1
  } action_t;

  typedef struct packed {
    logic valid;
    logic hit;
    key_t off_lo;
    key_t off_hi;
  } front_t;

  typedef struct packed {
    key_t  rem;
    quot_t q;
  } divq_t;

  typedef struct packed {
    logic  valid;
    logic  hit;
    quot_t q_lo;
    quot_t q_hi;
  } bucket_t;

  // One restoring division step for quotient bit pos.
  function automatic divq_t div_step(divq_t d, width_t w, int unsigned pos);
    key_t  dsr;
    divq_t r;
    r   = d;
    dsr = key_t'(w) << pos;
    if (d.rem >= dsr) begin
      r.rem = d.rem - dsr;
      r.q[pos[QUOT_IDX_BITS-1:0]] = 1'b1;
    end
    return r;
  endfunction

endpackage

// File: src/hrbm_front.sv
// Hash range bucket mask: partition registers, bucket width, input register
// and clipping stage. Depends on hrbm_pkg.
module hrbm_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [hrbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  hrbm_pkg::key_t                     cfg_data,
  input  logic                               take,
  input  logic                               action,
  input  hrbm_pkg::key_t                     key_low,
  input  hrbm_pkg::key_t                     key_high,
  output hrbm_pkg::width_t                   width,
  output hrbm_pkg::front_t                   front
);

  hrbm_pkg::key_t partition_low;
  hrbm_pkg::key_t partition_high;
  logic           part_empty;

  logic           s0_valid;
  logic           s0_action;
  hrbm_pkg::key_t s0_klo;
  hrbm_pkg::key_t s0_khi;

  logic [hrbm_pkg::KEY_BITS:0] range;
  hrbm_pkg::key_t              from_key;
  hrbm_pkg::key_t              to_key;
  hrbm_pkg::front_t            front_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_low  <= '0;
      partition_high <= '1;
    end else if (cfg_write) begin
      unique case (hrbm_pkg::cfg_reg_t'(cfg_index))
        hrbm_pkg::REG_PARTITION_LOW:  partition_low  <= cfg_data;
        hrbm_pkg::REG_PARTITION_HIGH: partition_high <= cfg_data;
      endcase
    end
  end

  // width = ceil(range / MASK_BITS)
  assign range = {1'b0, partition_high} - {1'b0, partition_low} + 1'b1;

  always_ff @(posedge clk) begin
    part_empty <= partition_high < partition_low;
    width      <= hrbm_pkg::width_t'(range[hrbm_pkg::KEY_BITS:hrbm_pkg::QUOT_BITS])
                + hrbm_pkg::width_t'(|range[hrbm_pkg::QUOT_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= take;
    end
    if (take) begin
      s0_action <= action;
      s0_klo    <= key_low;
      s0_khi    <= key_high;
    end
  end

  always_comb begin
    from_key         = (s0_klo > partition_low) ? s0_klo : partition_low;
    to_key           = (s0_khi < partition_high) ? s0_khi : partition_high;
    front_next.valid = s0_valid;
    if (hrbm_pkg::action_t'(s0_action) == hrbm_pkg::ACT_POINT) begin
      front_next.hit    = !part_empty && s0_klo >= partition_low
                          && s0_klo <= partition_high;
      front_next.off_lo = s0_klo - partition_low;
      front_next.off_hi = s0_klo - partition_low;
    end else begin
      front_next.hit    = !part_empty && from_key <= to_key;
      front_next.off_lo = from_key - partition_low;
      front_next.off_hi = to_key - partition_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else begin
      front.valid <= front_next.valid;
    end
    front.hit    <= front_next.hit;
    front.off_lo <= front_next.off_lo;
    front.off_hi <= front_next.off_hi;
  end

endmodule

// File: src/hrbm_div.sv
// Hash range bucket mask: pipelined restoring divider, two lanes (clipped
// start and end offset by bucket width). Depends on hrbm_pkg.
module hrbm_div (
  input  logic              clk,
  input  logic              rst,
  input  hrbm_pkg::width_t  width,
  input  hrbm_pkg::front_t  front,
  output hrbm_pkg::bucket_t bucket
);

  localparam int Last = hrbm_pkg::DIV_STAGES - 1;

  logic            stage_valid [hrbm_pkg::DIV_STAGES];
  logic            stage_hit   [hrbm_pkg::DIV_STAGES];
  hrbm_pkg::divq_t lo_d        [hrbm_pkg::DIV_STAGES];
  hrbm_pkg::divq_t hi_d        [hrbm_pkg::DIV_STAGES];

  for (genvar s = 0; s < hrbm_pkg::DIV_STAGES; s++) begin : g_stage
    logic            valid_in;
    logic            hit_in;
    hrbm_pkg::divq_t lo_in;
    hrbm_pkg::divq_t hi_in;
    hrbm_pkg::divq_t lo_n;
    hrbm_pkg::divq_t hi_n;

    if (s == 0) begin : g_first
      assign valid_in = front.valid;
      assign hit_in   = front.hit;
      assign lo_in    = '{rem: front.off_lo, q: '0};
      assign hi_in    = '{rem: front.off_hi, q: '0};
    end else begin : g_next
      assign valid_in = stage_valid[s-1];
      assign hit_in   = stage_hit[s-1];
      assign lo_in    = lo_d[s-1];
      assign hi_in    = hi_d[s-1];
    end

    always_comb begin
      lo_n = lo_in;
      hi_n = hi_in;
      for (int j = 0; j < hrbm_pkg::STEPS_PER_STAGE; j++) begin
        lo_n = hrbm_pkg::div_step(lo_n, width,
                 hrbm_pkg::QUOT_BITS - 1 - s * hrbm_pkg::STEPS_PER_STAGE - j);
        hi_n = hrbm_pkg::div_step(hi_n, width,
                 hrbm_pkg::QUOT_BITS - 1 - s * hrbm_pkg::STEPS_PER_STAGE - j);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[s] <= 1'b0;
      end else begin
        stage_valid[s] <= valid_in;
      end
      stage_hit[s] <= hit_in;
      lo_d[s]      <= lo_n;
      hi_d[s]      <= hi_n;
    end
  end

  assign bucket.valid = stage_valid[Last];
  assign bucket.hit   = stage_hit[Last];
  assign bucket.q_lo  = lo_d[Last].q;
  assign bucket.q_hi  = hi_d[Last].q;

`ifndef SYNTHESIS
  a_bucket_order: assert property (@(posedge clk) disable iff (rst)
    bucket.valid && bucket.hit |-> bucket.q_lo <= bucket.q_hi)
    else $error("low bucket above high bucket");
`endif

endmodule

// File: src/hrbm_mask.sv
// Hash range bucket mask: builds the bucket mask and drives the result
// register and strobe. Depends on hrbm_pkg.
module hrbm_mask (
  input  logic              clk,
  input  logic              rst,
  input  hrbm_pkg::bucket_t bucket,
  output logic              done,
  output hrbm_pkg::mask_t   bucket_mask
);

  hrbm_pkg::mask_t lo_part;
  hrbm_pkg::mask_t hi_part;
  hrbm_pkg::mask_t bucket_mask_next;

  always_comb begin
    lo_part = {hrbm_pkg::MASK_BITS{1'b1}} << bucket.q_lo;
    hi_part = {hrbm_pkg::MASK_BITS{1'b1}}
              >> (hrbm_pkg::quot_t'(hrbm_pkg::MASK_BITS - 1) - bucket.q_hi);
    bucket_mask_next = bucket.hit ? (lo_part & hi_part) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bucket.valid;
    end
    bucket_mask <= bucket_mask_next;
  end

endmodule

// File: src/hash_range_bucket_mask_unit.sv
// Hash range bucket mask: top level.
// Depends on hrbm_pkg, hrbm_front, hrbm_div and hrbm_mask.
//
// Usage:
//   Config: write partition_low (index 0) or partition_high (index 1) with
//   cfg_valid; cfg_ready is always high. Write only while no item is in
//   flight.
//   Input: an item (action, key_low, key_high) is taken on any edge with
//   start high and busy low; busy is always low, so one item per cycle.
//   Output: done rises together with the result, which is taken while done
//   is high; it passes through the input register, clip stage, three divider
//   stages of two quotient bits each and result register. Results come in input order.
//   Throughput is one item per clock; the divider is fully pipelined.
//   Reset (rst, synchronous): partition 0..65535, pipeline emptied, no
//   results pending. The receiver cannot stall; results are not held.
module hash_range_bucket_mask_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hrbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hrbm_pkg::KEY_BITS-1:0]       cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [hrbm_pkg::KEY_BITS-1:0]       key_low,
  input  logic [hrbm_pkg::KEY_BITS-1:0]       key_high,
  output logic                                done,
  output logic [hrbm_pkg::MASK_BITS-1:0]      bucket_mask
);

  hrbm_pkg::width_t  width;
  hrbm_pkg::front_t  front;
  hrbm_pkg::bucket_t bucket;
  logic              take;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign take      = start && !busy;

  hrbm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .action    (action),
    .key_low   (key_low),
    .key_high  (key_high),
    .width     (width),
    .front     (front)
  );

  hrbm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .width  (width),
    .front  (front),
    .bucket (bucket)
  );

  hrbm_mask u_mask (
    .clk         (clk),
    .rst         (rst),
    .bucket      (bucket),
    .done        (done),
    .bucket_mask (bucket_mask)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##(hrbm_pkg::LATENCY) done)
    else $error("item did not produce a result on time");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, hrbm_pkg::LATENCY))
    else $error("result without an accepted item");
`endif

endmodule

// File: sim/hash_range_bucket_mask_unit_test.sv
// Testbench for hash_range_bucket_mask_unit: directed and random items under several partitions,
// each bucket mask checked against an in-bench predictor through a scoreboard class.
// Depends on hrbm_pkg and hash_range_bucket_mask_unit only.
module hash_range_bucket_mask_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 124;

  class mask_scoreboard;
    hrbm_pkg::key_t  part_low;
    hrbm_pkg::key_t  part_high;
    hrbm_pkg::mask_t pending_masks[$];
    int unsigned     err_count;

    function new();
      part_low  = '0;
      part_high = '1;
      err_count = 0;
    endfunction

    function void set_reg(hrbm_pkg::cfg_reg_t idx, hrbm_pkg::key_t val);
      if (idx == hrbm_pkg::REG_PARTITION_LOW) begin
        part_low = val;
      end else begin
        part_high = val;
      end
    endfunction

    function int unsigned bucket_index(hrbm_pkg::key_t k, int unsigned bw);
      int unsigned b;
      b = (int'(k) - int'(part_low)) / bw;
      return (b > hrbm_pkg::MASK_BITS - 1) ? hrbm_pkg::MASK_BITS - 1 : b;
    endfunction

    function hrbm_pkg::mask_t predict_mask(hrbm_pkg::action_t act, hrbm_pkg::key_t klo,
                                           hrbm_pkg::key_t khi);
      int unsigned     range_len;
      int unsigned     bw;
      int unsigned     lo_b;
      int unsigned     hi_b;
      hrbm_pkg::key_t  from_k;
      hrbm_pkg::key_t  to_k;
      hrbm_pkg::mask_t all_ones;
      all_ones = '1;
      if (part_high < part_low) return '0;
      range_len = int'(part_high) - int'(part_low) + 1;
      bw = (range_len + hrbm_pkg::MASK_BITS - 1) / hrbm_pkg::MASK_BITS;
      if (bw == 0) bw = 1;
      if (act == hrbm_pkg::ACT_POINT) begin
        if (klo >= part_low && klo <= part_high) begin
          return hrbm_pkg::mask_t'(1) << bucket_index(klo, bw);
        end
        return '0;
      end
      from_k = (klo > part_low) ? klo : part_low;
      to_k   = (khi < part_high) ? khi : part_high;
      if (from_k > to_k) return '0;
      lo_b = bucket_index(from_k, bw);
      hi_b = bucket_index(to_k, bw);
      return (all_ones >> (hrbm_pkg::MASK_BITS - 1 - (hi_b - lo_b))) << lo_b;
    endfunction

    function void note_item(hrbm_pkg::action_t act, hrbm_pkg::key_t klo,
                            hrbm_pkg::key_t khi);
      pending_masks.push_back(predict_mask(act, klo, khi));
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      err_count++;
    endtask

    task check_mask(hrbm_pkg::mask_t got);
      hrbm_pkg::mask_t want;
      if (pending_masks.size() == 0) begin
        report($sformatf("bucket_mask %h with no item pending", got));
      end else begin
        want = pending_masks.pop_front();
        if (got !== want) begin
          report($sformatf("bucket_mask %h, expected %h", got, want));
        end
      end
    endtask

    task finish_check();
      if (pending_masks.size() != 0) begin
        report($sformatf("%0d results never arrived", pending_masks.size()));
      end
    endtask
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [hrbm_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [hrbm_pkg::KEY_BITS-1:0]       cfg_data = '0;
  logic                                start = 1'b0;
  logic                                busy;
  logic                                action = 1'b0;
  logic [hrbm_pkg::KEY_BITS-1:0]       key_low = '0;
  logic [hrbm_pkg::KEY_BITS-1:0]       key_high = '0;
  logic                                done;
  logic [hrbm_pkg::MASK_BITS-1:0]      bucket_mask;

  int unsigned    cycle_count = 0;
  mask_scoreboard sb = new();

  hash_range_bucket_mask_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .key_low     (key_low),
    .key_high    (key_high),
    .done        (done),
    .bucket_mask (bucket_mask)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(hrbm_pkg::action_t'(action), key_low, key_high);
      if (done) sb.check_mask(bucket_mask);
    end
  end

  task send_item(hrbm_pkg::action_t act, hrbm_pkg::key_t klo, hrbm_pkg::key_t khi,
                 int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    action   <= act;
    key_low  <= klo;
    key_high <= khi;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and let every pending result come back
  task drain();
    start <= 1'b0;
    while (sb.pending_masks.size() != 0) @(posedge clk);
    repeat (hrbm_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task write_reg(hrbm_pkg::cfg_reg_t idx, hrbm_pkg::key_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task set_partition(hrbm_pkg::key_t plo, hrbm_pkg::key_t phi);
    drain();
    write_reg(hrbm_pkg::REG_PARTITION_LOW, plo);
    write_reg(hrbm_pkg::REG_PARTITION_HIGH, phi);
    cfg_valid <= 1'b0;
  endtask

  function automatic hrbm_pkg::key_t pick_key(hrbm_pkg::key_t plo, hrbm_pkg::key_t phi);
    case ($urandom_range(0, 7))
      0, 1:    return hrbm_pkg::key_t'($urandom);
      2:       return plo + hrbm_pkg::key_t'($urandom_range(0, 70));
      3:       return phi - hrbm_pkg::key_t'($urandom_range(0, 70));
      4:       return plo - hrbm_pkg::key_t'($urandom_range(1, 40));
      5:       return phi + hrbm_pkg::key_t'($urandom_range(1, 40));
      6:       return $urandom_range(0, 1) ? hrbm_pkg::key_t'('1) : hrbm_pkg::key_t'('0);
      default: return hrbm_pkg::key_t'($urandom_range(plo, phi));
    endcase
  endfunction

  task random_items(int unsigned count);
    hrbm_pkg::action_t act;
    hrbm_pkg::key_t    a;
    hrbm_pkg::key_t    b;
    hrbm_pkg::key_t    t;
    bit                burst;
    int unsigned       i;
    burst = 1'b0;
    for (i = 0; i < count; i++) begin
      if (i % 30 == 0) burst = ($urandom_range(0, 3) == 0);
      act = hrbm_pkg::action_t'($urandom_range(0, 1));
      a   = pick_key(sb.part_low, sb.part_high);
      b   = pick_key(sb.part_low, sb.part_high);
      // mostly well-formed regions, some inverted
      if (act == hrbm_pkg::ACT_REGION && a > b && $urandom_range(0, 9) < 7) begin
        t = a;
        a = b;
        b = t;
      end
      send_item(act, a, b, burst ? 0 : $urandom_range(0, 19));
    end
  endtask

  initial begin
    hrbm_pkg::key_t plo;
    hrbm_pkg::key_t phi;
    int unsigned    p;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset partition, full key space
    send_item(hrbm_pkg::ACT_POINT, 16'h0000, 16'h0000, 0);
    send_item(hrbm_pkg::ACT_POINT, 16'hFFFF, 16'h0000, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'h0000, 16'hFFFF, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'hFFFF, 16'h0000, 3);
    send_item(hrbm_pkg::ACT_REGION, 16'd1024, 16'd1024, 0);

    set_partition(16'd1000, 16'd4999);
    send_item(hrbm_pkg::ACT_POINT, 16'd999, 16'd0, 0);
    send_item(hrbm_pkg::ACT_POINT, 16'd5000, 16'd0, 0);
    send_item(hrbm_pkg::ACT_POINT, 16'd1000, 16'hFFFF, 0);
    send_item(hrbm_pkg::ACT_POINT, 16'd4999, 16'd0, 2);
    send_item(hrbm_pkg::ACT_REGION, 16'd5000, 16'd6000, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'd0, 16'd999, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'd3000, 16'd2000, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'd0, 16'hFFFF, 1);
    send_item(hrbm_pkg::ACT_REGION, 16'd1000, 16'd1062, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'd1062, 16'd1063, 0);

    set_partition(16'd5000, 16'd1000);
    send_item(hrbm_pkg::ACT_POINT, 16'd3000, 16'd0, 0);
    send_item(hrbm_pkg::ACT_REGION, 16'd0, 16'hFFFF, 0);

    set_partition(16'h0000, 16'hFFFF);
    random_items(PHASE_ITEMS);
    set_partition(16'h0000, 16'h0000);
    random_items(PHASE_ITEMS);
    set_partition(16'hFFFF, 16'hFFFF);
    random_items(PHASE_ITEMS);
    set_partition(16'd0, 16'd63);
    random_items(PHASE_ITEMS);
    set_partition(16'd0, 16'd64);
    random_items(PHASE_ITEMS);
    set_partition(16'd12345, 16'd54321);
    random_items(PHASE_ITEMS);
    set_partition(16'd65472, 16'hFFFF);
    random_items(PHASE_ITEMS);
    set_partition(16'd40000, 16'd100);
    random_items(PHASE_ITEMS);
    set_partition(16'h0000, 16'hFFFE);
    random_items(PHASE_ITEMS);
    set_partition(16'h0001, 16'hFFFF);
    random_items(PHASE_ITEMS);

    for (p = 0; p < 5; p++) begin
      plo = hrbm_pkg::key_t'($urandom);
      if ($urandom_range(0, 1)) begin
        phi = hrbm_pkg::key_t'($urandom_range(plo, 16'hFFFF));
      end else begin
        phi = plo + hrbm_pkg::key_t'($urandom_range(0, 300));
      end
      set_partition(plo, phi);
      random_items(PHASE_ITEMS);
    end

    drain();
    sb.finish_check();
    if (sb.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
